[rtl/core/dq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, controller states and the
// command/status bundles between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SUM_W     = ADDR_W + 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int S_PAD_W   = S_TDATA_W - VALUE_W;
    localparam int M_TDATA_W = ((VALUE_W + CNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_RESP = 2'd2
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;      // capture the accepted operation and value
        logic    commit;    // capture the result and read the memory
        logic    mem_wr;    // write the push value
        logic    wr_front;  // write slot ahead of head, else slot past tail
        logic    rd_back;   // read the last entry, else the head entry
        logic    head_inc;
        logic    head_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    clear;
        logic    data_sel;  // result carries memory data, else zero
        status_t status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/dq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the deque: accept, execute, hand off the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire dq_pkg::sts_t sts,
    output dq_pkg::cmd_t      cmd
);

    dq_pkg::ctrl_state_t state_reg;
    dq_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dq_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        cmd.status = dq_pkg::STAT_OK;
        unique case (state_reg)
            dq_pkg::CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = dq_pkg::CS_EXEC;
                end
            end
            dq_pkg::CS_EXEC: begin
                cmd.commit = 1'b1;
                state_next = dq_pkg::CS_RESP;
                unique case (sts.op)
                    dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
                        if (sts.full) begin
                            cmd.status = dq_pkg::STAT_FULL;
                        end else begin
                            cmd.mem_wr   = 1'b1;
                            cmd.cnt_inc  = 1'b1;
                            cmd.wr_front = (sts.op == dq_pkg::OP_PUSH_FRONT);
                            cmd.head_dec = (sts.op == dq_pkg::OP_PUSH_FRONT);
                        end
                    end
                    dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
                        if (sts.empty) begin
                            cmd.status = dq_pkg::STAT_EMPTY;
                        end else begin
                            cmd.data_sel = 1'b1;
                            cmd.head_inc = (sts.op == dq_pkg::OP_POP_FRONT);
                            cmd.cnt_dec  = (sts.op == dq_pkg::OP_POP_FRONT);
                        end
                    end
                    dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
                        cmd.rd_back = 1'b1;
                        if (sts.empty) begin
                            cmd.status = dq_pkg::STAT_EMPTY;
                        end else begin
                            cmd.data_sel = 1'b1;
                            cmd.cnt_dec  = (sts.op == dq_pkg::OP_POP_BACK);
                        end
                    end
                    dq_pkg::OP_SIZE: begin
                    end
                    dq_pkg::OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                endcase
            end
            dq_pkg::CS_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = dq_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = dq_pkg::CS_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels open at once");

    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dq_pkg::CS_EXEC) |=> m_tvalid)
        else $error("result not offered after execute");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> !sts.full)
        else $error("write commanded into a full queue");
`endif

endmodule
`default_nettype wire

[rtl/core/dq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Slot memory, head pointer, entry count and the result register.
// ----------------------------------------------------------------------------
module dq_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dq_pkg::op_t                   in_op,
    input  wire logic [dq_pkg::VALUE_W-1:0]    in_value,
    input  wire dq_pkg::cmd_t                  cmd,
    output dq_pkg::sts_t                       sts,
    output dq_pkg::status_t                    res_status,
    output logic [dq_pkg::VALUE_W-1:0]         res_value,
    output logic [dq_pkg::CNT_W-1:0]           res_count
);

    logic [dq_pkg::VALUE_W-1:0] slot_mem [dq_pkg::DEPTH];

    dq_pkg::op_t                op_reg;
    logic [dq_pkg::VALUE_W-1:0] value_reg;
    logic [dq_pkg::ADDR_W-1:0]  head_reg;
    logic [dq_pkg::ADDR_W-1:0]  head_next;
    logic [dq_pkg::CNT_W-1:0]   count_reg;
    logic [dq_pkg::CNT_W-1:0]   count_next;
    logic [dq_pkg::VALUE_W-1:0] rd_data_reg;
    logic                       data_sel_reg;
    dq_pkg::status_t            status_reg;
    logic [dq_pkg::CNT_W-1:0]   occ_reg;

    logic [dq_pkg::SUM_W-1:0]   tail_sum;
    logic [dq_pkg::SUM_W-1:0]   last_sum;
    logic [dq_pkg::ADDR_W-1:0]  tail_addr;
    logic [dq_pkg::ADDR_W-1:0]  last_addr;
    logic [dq_pkg::ADDR_W-1:0]  head_prev;
    logic [dq_pkg::ADDR_W-1:0]  head_succ;
    logic [dq_pkg::ADDR_W-1:0]  wr_addr;
    logic [dq_pkg::ADDR_W-1:0]  rd_addr;

    // Ring arithmetic: every sum stays below twice the depth, so one
    // compare and subtract wraps it.
    always_comb begin
        tail_sum  = dq_pkg::SUM_W'(head_reg) + dq_pkg::SUM_W'(count_reg);
        last_sum  = tail_sum - dq_pkg::SUM_W'(1);
        tail_addr = (tail_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                  ? dq_pkg::ADDR_W'(tail_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                  : dq_pkg::ADDR_W'(tail_sum);
        last_addr = (last_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                  ? dq_pkg::ADDR_W'(last_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                  : dq_pkg::ADDR_W'(last_sum);
        head_prev = (head_reg == '0)
                  ? dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)
                  : head_reg - dq_pkg::ADDR_W'(1);
        head_succ = (head_reg == dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1))
                  ? '0
                  : head_reg + dq_pkg::ADDR_W'(1);
        wr_addr   = cmd.wr_front ? head_prev : tail_addr;
        rd_addr   = cmd.rd_back ? last_addr : head_reg;
    end

    always_comb begin
        head_next = head_reg;
        priority if (cmd.clear) begin
            head_next = '0;
        end else if (cmd.head_dec) begin
            head_next = head_prev;
        end else if (cmd.head_inc) begin
            head_next = head_succ;
        end
    end

    always_comb begin
        count_next = count_reg;
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.cnt_inc) begin
            count_next = count_reg + dq_pkg::CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - dq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.commit) begin
            status_reg   <= cmd.status;
            data_sel_reg <= cmd.data_sel;
            occ_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            slot_mem[wr_addr] <= value_reg;
        end
        if (cmd.commit) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign sts.op      = op_reg;
    assign sts.empty   = (count_reg == '0);
    assign sts.full    = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign res_status  = status_reg;
    assign res_value   = data_sel_reg ? rd_data_reg : '0;
    assign res_count   = occ_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (count_reg == '0) && (head_reg == '0))
        else $error("clear left pointers set");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 64-bit values in a 1024-slot ring buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_ channel carries one operation in s_tuser (push
//   back/front, pop front/back, peek front/back, size, clear) and the push
//   value in s_tdata. Each operation yields exactly one transfer on the m_
//   channel: status in m_tuser (ok, empty error, full with push dropped),
//   the popped or peeked value and the entry count left in m_tdata.
//   Each operation passes from the accept state through the execute state,
//   which registers the result and the read of the slot memory, to the
//   respond state, where m_tvalid is raised. A new operation is accepted
//   only after the last result transfers, as the accept/execute/respond
//   controller works around the registered read port of the slot memory.
//   When the receiver stalls, the result holds on m_tdata/m_tuser and
//   s_tready stays low until the result transfer completes.
//   Reset (aresetn low at a clock edge) empties the queue and sets the head
//   to slot zero; slot contents are not cleared, and no clearing pass runs,
//   so the block takes input from the first cycle after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // slave side
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dq_pkg::S_TDATA_W-1:0]    s_tdata,  // [63:0] push_value
    input  wire logic [dq_pkg::OP_W-1:0]         s_tuser,  // [2:0] operation
    // master side
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]         m_tdata,  // [63:0] read_value,
                                                           // [74:64] occupancy
    output logic [dq_pkg::STATUS_W-1:0]          m_tuser   // [1:0] status
);

    dq_pkg::cmd_t               cmd;
    dq_pkg::sts_t               sts;
    dq_pkg::status_t            res_status;
    logic [dq_pkg::VALUE_W-1:0] res_value;
    logic [dq_pkg::CNT_W-1:0]   res_count;

    // Sequence each transfer through accept, execute and respond
    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the slots, pointers and the result register
    dq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (dq_pkg::op_t'(s_tuser)),
        .in_value   (s_tdata[dq_pkg::VALUE_W-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .res_status (res_status),
        .res_value  (res_value),
        .res_count  (res_count)
    );

    // Pack the result: value lowest, count above, zero fill to bytes
    assign m_tdata = {{dq_pkg::M_PAD_W{1'b0}}, res_count, res_value};
    assign m_tuser = res_status;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring-buffer deque. A mirror of the buffer
// predicts status, read value and occupancy for every accepted operation.
// Each result transfer is compared with the oldest prediction. Stimulus is
// a directed opening, random mixes, and a full fill with pushes at full,
// partial drain and clear. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import dq_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [63:0]      read_value;
        logic [CNT_W-1:0] occupancy;
    } deque_result_t;

    // Mirror of the ring buffer plus the queue of predicted results
    class deque_mirror;
        logic [63:0]   slot_mirror [DEPTH];
        int            head_slot;
        int            count;
        deque_result_t pending_results [$];
        int            errors;
        int            ops_seen;
        int            full_pushes;
        int            empty_reads;
        int            peak_count;

        function new();
            head_slot   = 0;
            count       = 0;
            errors      = 0;
            ops_seen    = 0;
            full_pushes = 0;
            empty_reads = 0;
            peak_count  = 0;
        endfunction

        function int slot_index(int offset);
            return (head_slot + offset) % DEPTH;
        endfunction

        // Advance the mirror by one accepted operation and queue its result
        function void note_operation(op_t op, logic [63:0] push_value);
            deque_result_t res;
            res.status     = STAT_OK;
            res.read_value = '0;
            ops_seen++;
            case (op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (count >= DEPTH) begin
                        res.status = STAT_FULL;
                        full_pushes++;
                    end else if (op == OP_PUSH_BACK) begin
                        slot_mirror[slot_index(count)] = push_value;
                        count++;
                    end else begin
                        head_slot = slot_index(DEPTH - 1);
                        slot_mirror[head_slot] = push_value;
                        count++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                    if (count == 0) begin
                        res.status = STAT_EMPTY;
                        empty_reads++;
                    end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
                        res.read_value = slot_mirror[head_slot];
                        if (op == OP_POP_FRONT) begin
                            head_slot = slot_index(1);
                            count--;
                        end
                    end else begin
                        res.read_value = slot_mirror[slot_index(count - 1)];
                        if (op == OP_POP_BACK)
                            count--;
                    end
                end
                OP_SIZE: ;
                default: begin
                    head_slot = 0;
                    count     = 0;
                end
            endcase
            if (count > peak_count)
                peak_count = count;
            res.occupancy = count[CNT_W-1:0];
            pending_results.insert(pending_results.size(), res);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [1:0] status, logic [63:0] read_value,
                                   logic [CNT_W-1:0] occupancy);
            deque_result_t exp_res;
            if (pending_results.size() == 0) begin
                $error("result transfer with no prediction waiting");
                errors++;
                return;
            end
            exp_res = pending_results[0];
            pending_results.delete(0);
            if (status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
            if (read_value !== exp_res.read_value) begin
                $error("read_value: expected %h, got %h", exp_res.read_value, read_value);
                errors++;
            end
            if (occupancy !== exp_res.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_res.occupancy, occupancy);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    deque_mirror sb = new();
    int          src_idle_max  = 4;
    int          sink_idle_max = 4;
    int          src_sent      = 0;

    always #5 aclk = ~aclk;

    double_ended_queue_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [63:0] push_value
        .s_tuser  (s_tuser),   // [2:0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [63:0] read_value, [74:64] occupancy
        .m_tuser  (m_tuser)    // [1:0] status
    );

    function automatic logic [63:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 64'h7FFF_FFFF_FFFF_FFFF;
            1:       return 64'h8000_0000_0000_0000;
            2:       return 64'h0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Weighted mix of all eight operations
    function automatic op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)      return OP_PUSH_BACK;
        else if (r < 42) return OP_PUSH_FRONT;
        else if (r < 55) return OP_POP_FRONT;
        else if (r < 68) return OP_POP_BACK;
        else if (r < 78) return OP_PEEK_FRONT;
        else if (r < 88) return OP_PEEK_BACK;
        else if (r < 96) return OP_SIZE;
        else             return OP_CLEAR;
    endfunction

    // Offer one operation, hold it until the transfer, then note it
    task automatic send_op(op_t op, logic [63:0] value);
        int gap;
        if (src_sent % 40 == 0)
            src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
        src_sent++;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_operation(op, value);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, check every transfer
    initial begin
        int stall;
        int taken;
        taken    = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0)
                sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            stall = $urandom_range(0, sink_idle_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            sb.check_result(m_tuser, m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: CNT_W]);
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        aresetn  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // Directed: reads on empty, extreme values, wrap of head below zero,
        // both ends, clear and reads after clear
        send_op(OP_SIZE,       64'h0);
        send_op(OP_POP_FRONT,  64'h0);
        send_op(OP_POP_BACK,   '1);
        send_op(OP_PEEK_FRONT, 64'h0);
        send_op(OP_PEEK_BACK,  '1);
        send_op(OP_PUSH_BACK,  64'h7FFF_FFFF_FFFF_FFFF);
        send_op(OP_PUSH_FRONT, 64'h8000_0000_0000_0000);
        send_op(OP_PUSH_BACK,  64'h0);
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_PEEK_FRONT, 64'h1234);
        send_op(OP_PEEK_BACK,  64'h0);
        send_op(OP_SIZE,       '1);
        send_op(OP_POP_FRONT,  64'h0);
        send_op(OP_POP_BACK,   64'h0);
        send_op(OP_POP_FRONT,  64'h0);
        send_op(OP_POP_BACK,   64'h0);
        send_op(OP_POP_BACK,   64'h0);
        send_op(OP_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(OP_PUSH_BACK,  64'h5555_5555_5555_5555);
        send_op(OP_CLEAR,      '1);
        send_op(OP_PEEK_FRONT, 64'h0);
        send_op(OP_SIZE,       64'h0);
        send_op(OP_PUSH_FRONT, 64'h1);
        send_op(OP_POP_BACK,   64'h0);

        // Random mix at low occupancy
        repeat (180) send_op(pick_op(), pick_value());

        // Pause the sender until the block has answered everything
        drain_results();

        // Fill to the top from both ends, with some reads in between
        while (sb.count < DEPTH) begin
            case ($urandom_range(0, 39))
                0:       send_op(OP_PEEK_FRONT, pick_value());
                1:       send_op(OP_PEEK_BACK, pick_value());
                2:       send_op(OP_SIZE, pick_value());
                3:       send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                                 pick_value());
                default: send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                                 pick_value());
            endcase
        end

        // At full: pushes are dropped; refill whenever a pop opens a slot
        send_op(OP_PUSH_BACK,  pick_value());
        send_op(OP_PUSH_FRONT, pick_value());
        repeat (20) begin
            if (sb.count < DEPTH)
                send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
            else
                send_op(op_t'($urandom_range(OP_PUSH_BACK, OP_SIZE)), pick_value());
        end

        // Partial drain from both ends, then clear a nearly full buffer
        repeat (60) begin
            case ($urandom_range(0, 4))
                0:       send_op(OP_PEEK_BACK, pick_value());
                1:       send_op(OP_PEEK_FRONT, pick_value());
                default: send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                                 pick_value());
            endcase
        end
        send_op(OP_CLEAR, pick_value());

        // Random mix again after clear
        repeat (100) send_op(pick_op(), pick_value());

        drain_results();
        repeat (10) @(posedge aclk);

        $display("Checked %0d operations: %0d pushes dropped at full, %0d reads on empty,",
                 sb.ops_seen, sb.full_pushes, sb.empty_reads);
        $display("peak occupancy %0d of %0d, %0d mismatches", sb.peak_count, DEPTH, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
